@@ sv/greedy_change_optimality_test_unit_defines.svh @@
// assertion macros for the greedy change test unit
`ifndef GREEDY_CHANGE_OPTIMALITY_TEST_UNIT_DEFINES_SVH
`define GREEDY_CHANGE_OPTIMALITY_TEST_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define GCT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("gct check failed");
`define GCT_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("gct check failed");
`else
`define GCT_ASSERT(label, clk, rst_n, prop)
`define GCT_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ sv/gct_pkg.sv @@
// ----------------------------------------------------------------------------
// gct_pkg
// shared types and constants of the greedy change optimality test unit
// ----------------------------------------------------------------------------
package gct_pkg;
    localparam int MAX_COINS = 16;
    localparam int COIN_BITS = 16;
    localparam int IDX_BITS  = $clog2(MAX_COINS);
    localparam int NUM_BITS  = $clog2(MAX_COINS + 1);
    localparam int WIDE_BITS = 2 * COIN_BITS + 8;

    typedef logic [COIN_BITS-1:0] coin_t;
    typedef logic [WIDE_BITS-1:0] wide_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic gr_start;     // start greedy on amount register
        logic gr_src_p;     // amount source: 1 = c[i-1]-1, 0 = candidate w
        logic gr_step;      // one greedy coin step
        logic gr_store;     // greedy pass writes greedy_counts
        logic cand_start;   // clear w and qm
        logic cand_step;    // one candidate coin step
        logic clr_n;
    } gct_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic better;       // qm < qg
    } gct_sts_t;
endpackage

@@ sv/gct_if.sv @@
// ----------------------------------------------------------------------------
// gct_in_if / gct_out_if
// valid-ready channels of the greedy change test unit
// ----------------------------------------------------------------------------
interface gct_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] denomination;
    logic        last_coin;
    modport source (output valid, denomination, last_coin, input ready);
    modport sink   (input valid, denomination, last_coin, output ready);
endinterface

interface gct_out_if;
    logic        valid;
    logic        ready;
    logic        greedy_optimal;
    logic [16:0] amount;
    logic [3:0]  coin_index;
    logic [15:0] coin_count;
    logic        last_result;
    modport source (output valid, greedy_optimal, amount, coin_index, coin_count,
                    last_result, input ready);
    modport sink   (input valid, greedy_optimal, amount, coin_index, coin_count,
                    last_result, output ready);
endinterface

@@ sv/gct_div.sv @@
// ----------------------------------------------------------------------------
// gct_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gct_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gct_pkg::wide_t      dividend,
    input  gct_pkg::coin_t      divisor,
    output logic                busy,
    output logic                done,
    output gct_pkg::wide_t      quotient,
    output gct_pkg::wide_t      remainder
);
    import gct_pkg::*;
    localparam int CNT_BITS = $clog2(WIDE_BITS + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    wide_t               q_reg, q_next;
    wide_t               r_reg, r_next;
    coin_t               d_reg, d_next;
    logic [WIDE_BITS:0]  trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[WIDE_BITS-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CNT_BITS'(WIDE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[WIDE_BITS-2:0], 1'b0};
            if (trial >= {{(WIDE_BITS+1-COIN_BITS){1'b0}}, d_reg})
            begin
                r_next    = WIDE_BITS'(trial - {{(WIDE_BITS+1-COIN_BITS){1'b0}}, d_reg});
                q_next[0] = 1'b1;
            end
            else
                r_next = WIDE_BITS'(trial);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

@@ sv/gct_datapath.sv @@
// ----------------------------------------------------------------------------
// gct_datapath
// coin store, greedy and candidate count arrays, shared divider
// ----------------------------------------------------------------------------
module gct_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gct_pkg::gct_cmd_t            cmd,
    input  logic [gct_pkg::IDX_BITS-1:0] i_idx,
    input  logic [gct_pkg::IDX_BITS-1:0] j_idx,
    input  logic [gct_pkg::IDX_BITS-1:0] k_idx,
    input  gct_pkg::coin_t               din,
    output gct_pkg::gct_sts_t            sts,
    output logic [gct_pkg::NUM_BITS-1:0] n_coins,
    output logic [16:0]                  amount_out,
    output logic [15:0]                  count_out
);
    `include "greedy_change_optimality_test_unit_defines.svh"
    import gct_pkg::*;

    coin_t  store [MAX_COINS];
    wide_t  gcnt  [MAX_COINS];
    wide_t  ccnt  [MAX_COINS];
    logic [NUM_BITS-1:0] n_reg, n_next;
    wide_t  amt_reg, w_reg, qm_reg, qg_reg;
    logic   div_start;
    wide_t  div_q, div_r, cnt_k, prod;
    logic   div_busy, div_done;
    coin_t  ck, p_val;

    assign ck    = store[k_idx];
    assign p_val = store[i_idx] - 1'b1;   // i_idx holds i-1

    always_comb
    begin
        n_next = n_reg;
        if (cmd.clr_n)
            n_next = '0;
        else if (cmd.load && n_reg < NUM_BITS'(MAX_COINS))
            n_next = n_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= '0;
        else
            n_reg <= n_next;
    end

    // greedy step: divide only when the coin fits
    assign div_start = cmd.gr_step && ck != '0 && wide_t'(ck) <= amt_reg && amt_reg != '0;

    gct_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(amt_reg), .divisor(ck),
        .busy(div_busy), .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    // candidate count k
    always_comb
    begin
        if (k_idx < j_idx)
            cnt_k = gcnt[k_idx];
        else if (k_idx == j_idx)
            cnt_k = gcnt[k_idx] + 1'b1;
        else
            cnt_k = '0;
    end
    assign prod = WIDE_BITS'(cnt_k[COIN_BITS:0] * ck);

    always_ff @(posedge clk)
    begin
        if (cmd.load && n_reg < NUM_BITS'(MAX_COINS))
            store[n_reg[IDX_BITS-1:0]] <= din;
        if (cmd.gr_start)
        begin
            amt_reg <= cmd.gr_src_p ? wide_t'(p_val) : w_reg;
            qg_reg  <= '0;
        end
        else if (div_done)
        begin
            amt_reg <= div_r;
            qg_reg  <= qg_reg + div_q;
            if (cmd.gr_store)
                gcnt[k_idx] <= div_q;
        end
        else if (cmd.gr_step && !div_start && cmd.gr_store)
            gcnt[k_idx] <= '0;
        if (cmd.cand_start)
        begin
            w_reg  <= '0;
            qm_reg <= '0;
        end
        else if (cmd.cand_step)
        begin
            ccnt[k_idx] <= cnt_k;
            w_reg       <= w_reg + prod;
            qm_reg      <= qm_reg + cnt_k;
        end
    end

    assign sts.div_busy = div_busy | div_start;
    assign sts.div_done = div_done;
    assign sts.better   = qm_reg < qg_reg;
    assign n_coins      = n_reg;
    assign amount_out   = w_reg[16:0];
    assign count_out    = ccnt[k_idx][15:0];

    `GCT_ASSERT(a_start_idle, clk, rst_n, div_start |-> !div_busy)
    `GCT_ASSERT(a_done_after_busy, clk, rst_n, div_done |-> $past(div_busy))
    `GCT_ASSERT(a_n_bound, clk, rst_n, n_reg <= NUM_BITS'(MAX_COINS))
endmodule

@@ sv/gct_ctrl.sv @@
// ----------------------------------------------------------------------------
// gct_ctrl
// sequencer over coin pairs, greedy steps and result emission
// ----------------------------------------------------------------------------
module gct_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_fire,
    input  logic                         in_last,
    input  gct_pkg::gct_sts_t            sts,
    input  logic [gct_pkg::NUM_BITS-1:0] n_coins,
    input  logic                         out_free,
    output gct_pkg::gct_cmd_t            cmd,
    output logic [gct_pkg::IDX_BITS-1:0] i_idx,
    output logic [gct_pkg::IDX_BITS-1:0] j_idx,
    output logic [gct_pkg::IDX_BITS-1:0] k_idx,
    output logic                         in_ready,
    output logic                         emit,
    output logic                         emit_opt,
    output logic                         emit_last
);
    `include "greedy_change_optimality_test_unit_defines.svh"
    import gct_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_IOUT  = 4'd1;
    localparam logic [3:0] S_GP    = 4'd2;
    localparam logic [3:0] S_GPW   = 4'd3;
    localparam logic [3:0] S_CAND  = 4'd4;
    localparam logic [3:0] S_GW    = 4'd5;
    localparam logic [3:0] S_GWW   = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_OPT   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;
    localparam logic [3:0] S_GWS   = 4'd10;
    localparam logic [3:0] S_GPS   = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [NUM_BITS-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, n_reg, n_next;

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg; n_next = n_reg;
        cmd = '0;
        emit = 1'b0; emit_opt = 1'b0; emit_last = 1'b0;
        in_ready = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        n_next = (n_coins < NUM_BITS'(MAX_COINS)) ? n_coins + 1'b1 : n_coins;
                        i_next = NUM_BITS'(1);
                        state_next = S_IOUT;
                    end
                end
            end
            S_IOUT:
            begin
                cmd.clr_n = 1'b1;
                if (i_reg >= n_reg)
                    state_next = S_OPT;
                else
                begin
                    cmd.gr_start = 1'b1; cmd.gr_src_p = 1'b1;
                    k_next = '0;
                    state_next = S_GP;
                end
            end
            S_GP:
            begin
                if (k_reg >= n_reg)
                begin
                    j_next = i_reg;
                    state_next = S_CAND;
                    cmd.cand_start = 1'b1;
                    k_next = '0;
                end
                else
                begin
                    cmd.gr_step = 1'b1; cmd.gr_store = 1'b1;
                    state_next = S_GPS;
                end
            end
            S_GPS:
            begin
                cmd.gr_store = 1'b1;
                if (sts.div_busy)
                    state_next = S_GPW;
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_GP;
                end
            end
            S_GPW:
            begin
                cmd.gr_store = 1'b1;
                if (sts.div_done)
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_GP;
                end
            end
            S_CAND:
            begin
                if (k_reg >= n_reg)
                begin
                    cmd.gr_start = 1'b1;
                    k_next = '0;
                    state_next = S_GW;
                end
                else
                begin
                    cmd.cand_step = 1'b1;
                    k_next = k_reg + 1'b1;
                end
            end
            S_GW:
            begin
                if (k_reg >= n_reg)
                    state_next = S_CMP;
                else
                begin
                    cmd.gr_step = 1'b1;
                    state_next = S_GWS;
                end
            end
            S_GWS:
            begin
                if (sts.div_busy)
                    state_next = S_GWW;
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_GW;
                end
            end
            S_GWW:
            begin
                if (sts.div_done)
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_GW;
                end
            end
            S_CMP:
            begin
                k_next = '0;
                if (sts.better)
                    state_next = S_EMIT;
                else if (j_reg + 1'b1 < n_reg)
                begin
                    j_next = j_reg + 1'b1;
                    cmd.cand_start = 1'b1;
                    state_next = S_CAND;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_IOUT;
                end
            end
            S_OPT:
            begin
                if (out_free)
                begin
                    emit = 1'b1; emit_opt = 1'b1; emit_last = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_last = (k_reg + 1'b1 == n_reg);
                    k_next = k_reg + 1'b1;
                    if (k_reg + 1'b1 == n_reg)
                        state_next = S_LOAD;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            i_reg <= '0; j_reg <= '0; k_reg <= '0; n_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; n_reg <= n_next;
        end
    end

    // i_idx carries i-1 so the datapath reads c[i-1]
    assign i_idx = IDX_BITS'(i_reg - 1'b1);
    assign j_idx = j_reg[IDX_BITS-1:0];
    assign k_idx = k_reg[IDX_BITS-1:0];

    `GCT_ASSERT(a_ready_load, clk, rst_n, in_ready |-> state_reg == S_LOAD)
    `GCT_ASSERT(a_emit_free, clk, rst_n, emit |-> out_free)
    `GCT_ASSERT(a_last_leaves, clk, rst_n, (emit && emit_last) |=> state_reg == S_LOAD)
endmodule

@@ sv/greedy_change_optimality_test_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_change_optimality_test_unit
// pearson test of greedy optimality for a loaded coin system
// ----------------------------------------------------------------------------
// channel  dir   words
// in_ch    in    one coin per word, last_coin starts the test
// out_ch   out   one word when optimal, else one count word per coin
//
// loading takes one word per in_ch handshake; the test then runs on one shared divider,
// which divides on a greedy step only when the coin fits, with
// about n^3/2 greedy steps in the worst case
// reset clears the controller, coin count and output valid flag
// out_ch stalls hold the result register; no new word is taken during the test
module greedy_change_optimality_test_unit (
    input  logic      clk,
    input  logic      rst_n,
    gct_in_if.sink    in_ch,
    gct_out_if.source out_ch
);
    `include "greedy_change_optimality_test_unit_defines.svh"
    import gct_pkg::*;

    gct_cmd_t            cmd;
    gct_sts_t            sts;
    logic [IDX_BITS-1:0] i_idx, j_idx, k_idx;
    logic [NUM_BITS-1:0] n_coins;
    logic [16:0]         amount_w;
    logic [15:0]         count_w;
    logic                in_ready, in_fire, emit, emit_opt, emit_last, out_free;
    logic                vld_reg, vld_next;
    logic                opt_reg, last_reg;
    logic [16:0]         amt_reg;
    logic [3:0]          idx_reg;
    logic [15:0]         cnt_reg;

    assign in_fire  = in_ch.valid && in_ready;
    assign out_free = !vld_reg || out_ch.ready;

    gct_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_ch.last_coin),
        .sts(sts), .n_coins(n_coins), .out_free(out_free), .cmd(cmd),
        .i_idx(i_idx), .j_idx(j_idx), .k_idx(k_idx), .in_ready(in_ready),
        .emit(emit), .emit_opt(emit_opt), .emit_last(emit_last)
    );

    gct_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .i_idx(i_idx), .j_idx(j_idx),
        .k_idx(k_idx), .din(COIN_BITS'(in_ch.denomination)), .sts(sts),
        .n_coins(n_coins), .amount_out(amount_w), .count_out(count_w)
    );

    always_comb
    begin
        vld_next = vld_reg;
        if (emit)
            vld_next = 1'b1;
        else if (out_ch.ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            opt_reg  <= emit_opt;
            last_reg <= emit_last;
            amt_reg  <= emit_opt ? '0 : amount_w;
            idx_reg  <= emit_opt ? '0 : 4'(k_idx);
            cnt_reg  <= emit_opt ? '0 : count_w;
        end
    end

    assign in_ch.ready           = in_ready;
    assign out_ch.valid          = vld_reg;
    assign out_ch.greedy_optimal = opt_reg;
    assign out_ch.amount         = amt_reg;
    assign out_ch.coin_index     = idx_reg;
    assign out_ch.coin_count     = cnt_reg;
    assign out_ch.last_result    = last_reg;

    `GCT_ASSERT(a_hold, clk, rst_n, (vld_reg && !out_ch.ready) |=> vld_reg)
    `GCT_ASSERT(a_no_overrun, clk, rst_n, emit |-> out_free)
    `GCT_ASSERT(a_opt_last, clk, rst_n, (vld_reg && opt_reg) |-> last_reg)
endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks the greedy change test unit against an in-bench predictor of the
// pearson test, with random coin systems, random gaps on both channels and
// long output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import gct_pkg::*;

    typedef struct packed {
        logic [15:0] denomination;
        logic        last_coin;
    } coin_word_t;

    typedef struct packed {
        logic        greedy_optimal;
        logic [16:0] amount;
        logic [3:0]  coin_index;
        logic [15:0] coin_count;
        logic        last_result;
    } verdict_word_t;

    localparam int IDLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    gct_in_if  in_ch ();
    gct_out_if out_ch ();

    greedy_change_optimality_test_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    coin_word_t    pending_coins[$];
    verdict_word_t expected_verdicts[$];

    // predictor state
    logic [63:0] held_coins[MAX_COINS];
    int          held_total;
    logic [63:0] cand[MAX_COINS];

    int errors;
    int send_gap;
    int recv_gap;
    int hold_off;
    int idle_cycles;
    bit hold_go;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] greedy_total(input logic [63:0] amt, input int n,
                                                 output logic [63:0] cnt[MAX_COINS]);
        logic [63:0] total;
        total = 0;
        for (int k = 0; k < MAX_COINS; k++)
        begin
            cnt[k] = 0;
            if (k < n && held_coins[k] != 0 && held_coins[k] <= amt && amt > 0)
            begin
                cnt[k] = amt / held_coins[k];
                amt    = amt % held_coins[k];
            end
            total += cnt[k];
        end
        return total;
    endfunction

    function automatic bit find_counterexample(input int n, output logic [63:0] w_out);
        logic [63:0] gc[MAX_COINS];
        logic [63:0] scratch[MAX_COINS];
        logic [63:0] p;
        logic [63:0] w;
        logic [63:0] qm;
        logic [63:0] qg;
        w_out = 0;
        for (int i = 1; i < n; i++)
        begin
            p  = (held_coins[i-1] - 64'd1) & 64'hFFFF;
            qg = greedy_total(p, n, gc);
            for (int j = i; j < n; j++)
            begin
                w  = 0;
                qm = 0;
                for (int k = 0; k < n; k++)
                begin
                    if (k < j)       cand[k] = gc[k];
                    else if (k == j) cand[k] = gc[k] + 64'd1;
                    else             cand[k] = 0;
                    w  += cand[k] * held_coins[k];
                    qm += cand[k];
                end
                qg = greedy_total(w, n, scratch);
                if (qm < qg)
                begin
                    w_out = w;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic predict_verdicts(input coin_word_t cw);
        verdict_word_t v;
        logic [63:0]   w;
        int            n;
        if (held_total < MAX_COINS)
        begin
            held_coins[held_total] = {48'd0, cw.denomination};
            held_total++;
        end
        if (!cw.last_coin)
            return;
        n = held_total;
        held_total = 0;
        if (!find_counterexample(n, w))
        begin
            v = '{1'b1, 17'd0, 4'd0, 16'd0, 1'b1};
            expected_verdicts.push_back(v);
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                v.greedy_optimal = 1'b0;
                v.amount         = w[16:0];
                v.coin_index     = k[3:0];
                v.coin_count     = cand[k][15:0];
                v.last_result    = (k + 1 == n);
                expected_verdicts.push_back(v);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input verdict_word_t got,
                                   input verdict_word_t want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        int gap_draw;
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.denomination <= '0;
            in_ch.last_coin    <= 1'b0;
            send_gap           <= 0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            predict_verdicts('{in_ch.denomination, in_ch.last_coin});
            void'(pending_coins.pop_front());
            gap_draw = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            if (gap_draw == 0 && pending_coins.size() > 0)
                {in_ch.denomination, in_ch.last_coin} <= pending_coins[0];
            else
            begin
                in_ch.valid <= 1'b0;
                send_gap    <= gap_draw;
            end
        end
        else if (!in_ch.valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_coins.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                {in_ch.denomination, in_ch.last_coin} <= pending_coins[0];
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        verdict_word_t got;
        verdict_word_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap     <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.greedy_optimal, out_ch.amount, out_ch.coin_index,
                        out_ch.coin_count, out_ch.last_result};
                if (expected_verdicts.size() == 0)
                    report_mismatch("unexpected word", got, '0);
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.greedy_optimal != want.greedy_optimal)
                        report_mismatch("greedy_optimal", got, want);
                    if (got.amount != want.amount)
                        report_mismatch("amount", got, want);
                    if (got.coin_index != want.coin_index)
                        report_mismatch("coin_index", got, want);
                    if (got.coin_count != want.coin_count)
                        report_mismatch("coin_count", got, want);
                    if (got.last_result != want.last_result)
                        report_mismatch("last_result", got, want);
                end
                recv_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
                out_ch.ready <= 1'b0;
            end
            else if (hold_off > 0)
                out_ch.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap     <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // long receiver hold-off, counted on its own
    initial
    begin
        hold_off = 0;
        wait (hold_go);
        @(posedge clk);
        hold_off <= 3000;
        repeat (3000) @(posedge clk) hold_off <= hold_off - 1;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_system(input int n, input bit greedy_friendly);
        coin_word_t  cw;
        logic [15:0] val;
        logic [15:0] top;
        top = $urandom_range(0, 7) == 0 ? 16'($urandom_range(1, 65535))
                                        : 16'($urandom_range(2, 200));
        val = top;
        for (int k = 0; k < n; k++)
        begin
            if (greedy_friendly)
            begin
                cw.denomination = (k == n - 1) ? 16'd1 : val;
                if (val > 1) val = 16'($urandom_range(1, val - 1));
            end
            else
                cw.denomination = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 60));
            cw.last_coin = (k == n - 1);
            pending_coins.push_back(cw);
        end
    endtask

    task automatic wait_drained();
        while (pending_coins.size() > 0 || in_ch.valid || expected_verdicts.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int sent;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: canonical, classic counterexample, single coin, extremes
        pending_coins.push_back('{16'd25, 1'b0});
        pending_coins.push_back('{16'd10, 1'b0});
        pending_coins.push_back('{16'd5, 1'b0});
        pending_coins.push_back('{16'd1, 1'b1});
        pending_coins.push_back('{16'd4, 1'b0});
        pending_coins.push_back('{16'd3, 1'b0});
        pending_coins.push_back('{16'd1, 1'b1});
        pending_coins.push_back('{16'hFFFF, 1'b1});
        // zero denomination and unordered values
        pending_coins.push_back('{16'd0, 1'b0});
        pending_coins.push_back('{16'd7, 1'b0});
        pending_coins.push_back('{16'hFFFF, 1'b1});
        // lowest coin not one, all bits across
        pending_coins.push_back('{16'hAAAA, 1'b0});
        pending_coins.push_back('{16'h5555, 1'b0});
        pending_coins.push_back('{16'd2, 1'b1});
        wait_drained();

        // too many coins: 18 words, last mark on a dropped one
        for (int k = 0; k < 18; k++)
            pending_coins.push_back('{16'(40 - 2 * k), k == 17});
        // receiver holds off while sender keeps offering
        hold_go = 1'b1;
        queue_system(5, 1'b0);
        queue_system(4, 1'b0);
        wait_drained();

        sent = 0;
        while (sent < 110)
        begin
            int n;
            n = $urandom_range(0, 9) == 0 ? $urandom_range(10, 16) : $urandom_range(1, 5);
            queue_system(n, $urandom_range(0, 1));
            sent += n;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            while (pending_coins.size() > 8)
                @(posedge clk);
        end
        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
